>>> rtl/csa_pkg.sv
// Package with shared types and constants for the contiguous slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package csa_pkg;

   localparam int CSA_SLOTS       = 22;
   localparam int CSA_SLOT_STRIDE = 16;
   localparam int SIZE_W          = 5;
   localparam int MAX_IW          = 6;
   localparam int MAX_CW          = 7;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      MARK_FREE = 2'd0,
      MARK_HEAD = 2'd1,
      MARK_CONT = 2'd2
   } csa_mark_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_FCHECK,
      ST_FSCAN,
      ST_DONE
   } csa_state_type;

   typedef struct packed {
      logic              func;
      logic [SIZE_W-1:0] base_size;
      logic [SIZE_W-1:0] requested_size;
      logic [SIZE_W-1:0] head_slot;
   } csa_req_type;

   typedef struct packed {
      logic              ok;
      logic [SIZE_W-1:0] start_slot;
      logic [8:0]        base_offset;
      logic [SIZE_W-1:0] run_length;
      logic [SIZE_W-1:0] free_slots;
      logic              fit_flag;
   } csa_rsp_type;

   typedef struct packed {
      logic              ok;
      logic              is_free;
      logic [MAX_IW-1:0] start;
      logic [MAX_CW-1:0] len;
   } csa_done_type;

endpackage
`default_nettype wire

>>> rtl/csa_mark_mem.sv
// Slot mark memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module csa_mark_mem #(
   parameter int SLOTS = csa_pkg::CSA_SLOTS,
   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IW-1:0]         wr_addr,
   input  wire csa_pkg::csa_mark_type wr_data,
   input  wire logic [IW-1:0]         rd_addr,
   output csa_pkg::csa_mark_type      rd_data_ff
);

   csa_pkg::csa_mark_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/csa_ctrl.sv
// Sequencer that clears, scans, fills and frees slot runs in the mark memory.
`timescale 1ns / 1ps
`default_nettype none
module csa_ctrl #(
   parameter int SLOTS = csa_pkg::CSA_SLOTS,
   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CW   = $clog2(SLOTS + 1),
   localparam int SW   = ((IW > csa_pkg::SIZE_W) ? IW : csa_pkg::SIZE_W) + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire csa_pkg::csa_req_type  req_data,
   output logic                       mem_wr_en,
   output logic [IW-1:0]              mem_wr_addr,
   output csa_pkg::csa_mark_type      mem_wr_data,
   output logic [IW-1:0]              mem_rd_addr,
   input  wire csa_pkg::csa_mark_type mem_rd_data,
   output logic                       done_valid,
   input  wire logic                  done_ready,
   output csa_pkg::csa_done_type      done_data
);

   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   csa_pkg::csa_state_type state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] wr_ff, wr_in;
   logic [csa_pkg::SIZE_W-1:0] cnt_ff, cnt_in;
   logic [csa_pkg::SIZE_W-1:0] len_ff, len_in;
   logic [csa_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [CW-1:0] n_ff, n_in;
   logic up_ff, up_in;
   logic ok_ff, ok_in;
   logic free_ff, free_in;

   logic                       req_up;
   logic [csa_pkg::SIZE_W-1:0] req_len;
   logic [csa_pkg::SIZE_W-1:0] cnt_inc;
   logic [SW-1:0]              up_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csa_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cur_ff  <= cur_in;
      head_ff <= head_in;
      wr_ff   <= wr_in;
      cnt_ff  <= cnt_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in;
      up_ff   <= up_in;
      ok_ff   <= ok_in;
      free_ff <= free_in;
   end

   always_comb begin
      req_up  = (req_data.requested_size == '0) ||
                (req_data.requested_size <= req_data.base_size);
      req_len = req_up ? req_data.base_size : req_data.requested_size;
      cnt_inc = cnt_ff + 1'b1;
      up_head = SW'(cur_ff) + SW'(1) - SW'(len_ff);
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      head_in     = head_ff;
      wr_in       = wr_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      n_in        = n_ff;
      up_in       = up_ff;
      ok_in       = ok_ff;
      free_in     = free_ff;
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = csa_pkg::MARK_FREE;
      mem_rd_addr = cur_ff;
      done_valid  = 1'b0;

      case (state_ff)
         csa_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         csa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               free_in = (req_data.func == csa_pkg::FUNC_FREE);
               ok_in   = 1'b0;
               cnt_in  = '0;
               n_in    = '0;
               if (req_data.func == csa_pkg::FUNC_ALLOC) begin
                  up_in  = req_up;
                  len_in = req_len;
                  if ((req_len == '0) || (int'(req_len) > SLOTS)) begin
                     state_in = csa_pkg::ST_DONE;
                  end else begin
                     cur_in      = req_up ? '0 : LAST;
                     mem_rd_addr = cur_in;
                     state_in    = csa_pkg::ST_SCAN;
                  end
               end else begin
                  if (int'(req_data.head_slot) >= SLOTS) begin
                     state_in = csa_pkg::ST_DONE;
                  end else begin
                     cur_in      = IW'(req_data.head_slot);
                     head_in     = IW'(req_data.head_slot);
                     mem_rd_addr = cur_in;
                     state_in    = csa_pkg::ST_FCHECK;
                  end
               end
            end
         end
         csa_pkg::ST_SCAN: begin
            if (mem_rd_data == csa_pkg::MARK_FREE) begin
               cnt_in = cnt_inc;
            end else begin
               cnt_in = '0;
            end
            if ((mem_rd_data == csa_pkg::MARK_FREE) && (cnt_inc >= len_ff)) begin
               head_in  = up_ff ? IW'(up_head) : cur_ff;
               wr_in    = up_ff ? IW'(up_head) : cur_ff;
               rem_in   = len_ff;
               ok_in    = 1'b1;
               state_in = csa_pkg::ST_FILL;
            end else if ((up_ff && (cur_ff == LAST)) || (!up_ff && (cur_ff == '0))) begin
               state_in = csa_pkg::ST_DONE;
            end else begin
               cur_in      = up_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
               mem_rd_addr = cur_in;
            end
         end
         csa_pkg::ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wr_ff;
            mem_wr_data = (wr_ff == head_ff) ? csa_pkg::MARK_HEAD : csa_pkg::MARK_CONT;
            wr_in       = wr_ff + 1'b1;
            rem_in      = rem_ff - 1'b1;
            if (rem_ff == csa_pkg::SIZE_W'(1)) begin
               state_in = csa_pkg::ST_DONE;
            end
         end
         csa_pkg::ST_FCHECK: begin
            if (mem_rd_data != csa_pkg::MARK_HEAD) begin
               state_in = csa_pkg::ST_DONE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = head_ff;
               n_in        = CW'(1);
               ok_in       = 1'b1;
               if (head_ff == LAST) begin
                  state_in = csa_pkg::ST_DONE;
               end else begin
                  cur_in      = head_ff + 1'b1;
                  mem_rd_addr = cur_in;
                  state_in    = csa_pkg::ST_FSCAN;
               end
            end
         end
         csa_pkg::ST_FSCAN: begin
            if (mem_rd_data == csa_pkg::MARK_CONT) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff;
               n_in        = n_ff + 1'b1;
               if (cur_ff == LAST) begin
                  state_in = csa_pkg::ST_DONE;
               end else begin
                  cur_in      = cur_ff + 1'b1;
                  mem_rd_addr = cur_in;
               end
            end else begin
               state_in = csa_pkg::ST_DONE;
            end
         end
         csa_pkg::ST_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      done_data.ok      = ok_ff;
      done_data.is_free = free_ff;
      done_data.start   = ok_ff ? csa_pkg::MAX_IW'(head_ff) : '0;
      if (!ok_ff) begin
         done_data.len = '0;
      end else if (free_ff) begin
         done_data.len = csa_pkg::MAX_CW'(n_ff);
      end else begin
         done_data.len = csa_pkg::MAX_CW'(len_ff);
      end
   end

endmodule
`default_nettype wire

>>> rtl/csa_rsp.sv
// Result register with the free-slot count and the all-fit flag.
`timescale 1ns / 1ps
`default_nettype none
module csa_rsp #(
   parameter int SLOTS       = csa_pkg::CSA_SLOTS,
   parameter int SLOT_STRIDE = csa_pkg::CSA_SLOT_STRIDE,
   localparam int CW         = $clog2(SLOTS + 1),
   localparam int PW         = csa_pkg::MAX_IW + 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 done_valid,
   output logic                      done_ready,
   input  wire csa_pkg::csa_done_type done_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output csa_pkg::csa_rsp_type      rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   csa_pkg::csa_rsp_type rsp_data_ff, rsp_data_in;
   logic [CW-1:0]        free_count_ff, free_count_in;
   logic                 all_fit_ff, all_fit_in;
   logic                 load;
   logic [PW-1:0]        offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         free_count_ff <= CW'(SLOTS);
         all_fit_ff    <= 1'b1;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         free_count_ff <= free_count_in;
         all_fit_ff    <= all_fit_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      done_ready    = !rsp_valid_ff || !rsp_stall;
      load          = done_valid && done_ready;
      offset        = PW'(done_data.start) * PW'(SLOT_STRIDE);
      free_count_in = free_count_ff;
      all_fit_in    = all_fit_ff;
      if (done_data.ok) begin
         if (done_data.is_free) begin
            free_count_in = free_count_ff + CW'(done_data.len);
            all_fit_in    = 1'b1;
         end else begin
            free_count_in = free_count_ff - CW'(done_data.len);
         end
      end else if (!done_data.is_free) begin
         all_fit_in = 1'b0;
      end
      if (!load) begin
         free_count_in = free_count_ff;
         all_fit_in    = all_fit_ff;
      end
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_data_in.ok          = done_data.ok;
         rsp_data_in.start_slot  = csa_pkg::SIZE_W'(done_data.start);
         rsp_data_in.base_offset = offset[8:0];
         rsp_data_in.run_length  = csa_pkg::SIZE_W'(done_data.len);
         rsp_data_in.free_slots  = csa_pkg::SIZE_W'(free_count_in);
         rsp_data_in.fit_flag    = all_fit_in;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

endmodule
`default_nettype wire

>>> rtl/contiguous_slot_allocator.sv
// Top level of the first-fit contiguous slot allocator.
// After reset the block clears every slot of the mark memory and takes no request until done.
// An allocate scans the marks for a free run of the requested length and then fills that run,
// the scan reading one mark and the fill writing one mark per cycle.
// A free checks for a head mark at the named slot, clears it and then clears the continuation
// slots after it, up to the top slot; a free that names no head or is out of range clears nothing.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_slot_allocator #(
   parameter int SLOTS       = csa_pkg::CSA_SLOTS,
   parameter int SLOT_STRIDE = csa_pkg::CSA_SLOT_STRIDE
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire csa_pkg::csa_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output csa_pkg::csa_rsp_type      rsp_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                  mem_wr_en;
   logic [IW-1:0]         mem_wr_addr;
   csa_pkg::csa_mark_type mem_wr_data;
   logic [IW-1:0]         mem_rd_addr;
   csa_pkg::csa_mark_type mem_rd_data;
   logic                  done_valid;
   logic                  done_ready;
   csa_pkg::csa_done_type done_data;

   csa_mark_mem #(
      .SLOTS(SLOTS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr   (mem_rd_addr),
      .rd_data_ff(mem_rd_data)
   );

   csa_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data)
   );

   csa_rsp #(
      .SLOTS      (SLOTS),
      .SLOT_STRIDE(SLOT_STRIDE)
   ) u_rsp (
      .clock     (clock),
      .reset     (reset),
      .done_valid(done_valid),
      .done_ready(done_ready),
      .done_data (done_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
